@@ rtl/blg_pkg.sv @@
// Package for the battery level gauge: field widths, the LiPo discharge table,
// controller states and the controller-to-datapath command word.
// No dependencies.
`default_nettype none

package blg_pkg;

	localparam int SAMPLE_W    = 11;
	localparam int LEVEL_W     = 7;
	localparam int MV_W        = 16;
	localparam int SCALE_W     = 16;
	localparam int AVG_W       = 10;
	localparam int SUMP_W      = 16;
	localparam int AVG_SHIFT   = 23;
	localparam int AVG_RECIP_W = AVG_SHIFT + 1;
	localparam int DIFF_W      = 9;
	localparam int SPP_W       = 5;
	localparam int NUM_W       = 12;
	localparam int RECIP_W     = 17;
	localparam int SPAN_SHIFT  = 21;
	localparam int NPTS        = 12;
	localparam int PT_W        = 4;
	localparam int SCALE_SHIFT = 10;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4800;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 7'd0;

	// register index, taken from paddr[2]
	localparam logic REG_SCALE = 1'b0;

	localparam logic [MV_W-1:0] LIPO_MV [NPTS] = '{
		16'd4200, 16'd4060, 16'd3980, 16'd3920, 16'd3870, 16'd3820,
		16'd3790, 16'd3770, 16'd3740, 16'd3680, 16'd3450, 16'd3000
	};
	localparam logic [LEVEL_W-1:0] LIPO_PCT [NPTS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
	};
	// ceil(2^SPAN_SHIFT / span) of the segment that ends at each point
	localparam logic [RECIP_W-1:0] SPAN_RECIP [NPTS] = '{
		17'd0, 17'd14980, 17'd26215, 17'd34953, 17'd41944, 17'd41944,
		17'd69906, 17'd104858, 17'd69906, 17'd34953, 17'd9119, 17'd4661
	};

	typedef enum logic [2:0] {
		ST_ACC,
		ST_AVG,
		ST_SCALE,
		ST_LOOKUP,
		ST_INTERP,
		ST_DIVIDE,
		ST_EMIT
	} blg_state_t;

	typedef struct packed {
		logic acc;
		logic acc_last;
		logic avg;
		logic scale;
		logic lookup;
		logic interp;
		logic divide;
		logic emit;
	} blg_cmd_t;

endpackage

`default_nettype wire

@@ rtl/blg_stream_if.sv @@
// Valid/ready channels of the battery level gauge: sample words in, level words out.
// Depends on blg_pkg.
`default_nettype none

interface blg_in_if import blg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface blg_out_if import blg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level_percent;
	logic [MV_W-1:0]    millivolts;

	modport source (output valid, output level_percent, output millivolts, input ready);
	modport sink (input valid, input level_percent, input millivolts, output ready);
endinterface

`default_nettype wire

@@ rtl/blg_ctrl.sv @@
// Sequencer of the battery level gauge: batch counter, output valid flag and
// the command word for the datapath. Depends on blg_pkg.
`default_nettype none

module blg_ctrl import blg_pkg::*; #(
	parameter int SAMPLES_PER_READING = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output blg_cmd_t  cmd
);

	localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);

	blg_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic             accept;
	logic             last;

	assign in_ready  = (state_q == ST_ACC);
	assign accept    = in_valid && in_ready;
	assign last      = (count_q == CNT_LAST);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACC: begin
				if (accept && last) state_nxt = ST_AVG;
			end
			ST_AVG:    state_nxt = ST_SCALE;
			ST_SCALE:  state_nxt = ST_LOOKUP;
			ST_LOOKUP: state_nxt = ST_INTERP;
			ST_INTERP: state_nxt = ST_DIVIDE;
			ST_DIVIDE: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) state_nxt = ST_ACC;
			end
			default: state_nxt = ST_ACC;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_ACC: begin
				cmd.acc      = accept && !last;
				cmd.acc_last = accept && last;
			end
			ST_AVG:    cmd.avg    = 1'b1;
			ST_SCALE:  cmd.scale  = 1'b1;
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_INTERP: cmd.interp = 1'b1;
			ST_DIVIDE: cmd.divide = 1'b1;
			ST_EMIT:   cmd.emit   = !out_valid_q || out_ready;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.acc_last) begin
				count_q <= '0;
			end else if (cmd.acc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(SAMPLES_PER_READING))
		else $error("batch counter out of range");

	a_last_starts_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (state_q == ST_AVG))
		else $error("closing sample did not start the average");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted level word not presented");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("level word dropped while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/blg_dp.sv @@
// Datapath of the battery level gauge: sample accumulator, reciprocal-multiply
// average and interpolation, scale multiplier, table lookup and output word. Depends on blg_pkg.
`default_nettype none

module blg_dp import blg_pkg::*; #(
	parameter int SAMPLES_PER_READING = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire blg_cmd_t                   cmd,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [SCALE_W-1:0]         scale,
	output logic [LEVEL_W-1:0]              level_percent,
	output logic [MV_W-1:0]                 millivolts
);

	localparam int SUM_W      = SAMPLE_W + $clog2(SAMPLES_PER_READING);
	localparam int AVG_PROD_W = SUMP_W + AVG_RECIP_W;
	localparam int PROD_W     = AVG_W + SCALE_W;
	localparam int FRAC_W     = NUM_W + RECIP_W;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(
		((1 << AVG_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

	logic signed [SUM_W-1:0] sum_q, sum_nxt;
	logic [SUMP_W-1:0]       sum_pos_q;
	logic [AVG_PROD_W-1:0]   avg_prod;
	logic [AVG_W-1:0]        avg_q;
	logic [PROD_W-1:0]       prod;
	logic [MV_W-1:0]         mv_q;
	logic [LEVEL_W-1:0]      base_q, base_nxt;
	logic [DIFF_W-1:0]       diff_q, diff_nxt;
	logic [SPP_W-1:0]        spp_q, spp_nxt;
	logic [RECIP_W-1:0]      recip_q, recip_nxt;
	logic [NUM_W-1:0]        num_q;
	logic [FRAC_W-1:0]       frac_prod;
	logic [LEVEL_W-1:0]      frac_q;
	logic [PT_W-1:0]         sel, sel_prev;
	logic                    hit;
	logic [LEVEL_W-1:0]      level_q;
	logic [MV_W-1:0]         mv_out_q;
	logic [MV_W-1:0]         mv_gap;

	assign sum_nxt   = sum_q + SUM_W'(sample);
	assign avg_prod  = AVG_PROD_W'(sum_pos_q) * AVG_PROD_W'(AVG_RECIP);
	assign prod      = PROD_W'(avg_q) * PROD_W'(scale);
	assign frac_prod = FRAC_W'(num_q) * FRAC_W'(recip_q);

	always_comb begin
		sel = '0;
		hit = 1'b0;
		for (int k = NPTS - 1; k >= 1; k--) begin
			if (mv_q >= LIPO_MV[k]) begin
				sel = PT_W'(k);
				hit = 1'b1;
			end
		end
	end

	assign sel_prev = sel - 1'b1;
	assign mv_gap   = mv_q - LIPO_MV[sel];

	always_comb begin
		base_nxt  = LEVEL_EMPTY;
		diff_nxt  = '0;
		spp_nxt   = '0;
		recip_nxt = '0;
		if (mv_q >= LIPO_MV[0]) begin
			base_nxt = LEVEL_FULL;
		end else if (hit) begin
			base_nxt  = LIPO_PCT[sel];
			diff_nxt  = mv_gap[DIFF_W-1:0];
			spp_nxt   = SPP_W'(LIPO_PCT[sel_prev] - LIPO_PCT[sel]);
			recip_nxt = SPAN_RECIP[sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_nxt;
		end else if (cmd.acc_last) begin
			sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_last) begin
			sum_pos_q <= sum_nxt[SUM_W-1] ? '0 : SUMP_W'(sum_nxt[SUM_W-2:0]);
		end
		if (cmd.avg) begin
			avg_q <= avg_prod[AVG_SHIFT +: AVG_W];
		end
		if (cmd.scale) begin
			mv_q <= prod[SCALE_SHIFT +: MV_W];
		end
		if (cmd.lookup) begin
			base_q  <= base_nxt;
			diff_q  <= diff_nxt;
			spp_q   <= spp_nxt;
			recip_q <= recip_nxt;
		end
		if (cmd.interp) begin
			num_q <= NUM_W'(diff_q) * NUM_W'(spp_q);
		end
		if (cmd.divide) begin
			frac_q <= frac_prod[SPAN_SHIFT +: LEVEL_W];
		end
		if (cmd.emit) begin
			level_q  <= base_q + frac_q;
			mv_out_q <= mv_q;
		end
	end

	assign level_percent = level_q;
	assign millivolts    = mv_out_q;

endmodule

`default_nettype wire

@@ rtl/battery_level_gauge_core.sv @@
// Top level of the battery level gauge: APB scale register, sequencer and datapath.
// Depends on blg_pkg, blg_stream_if, blg_ctrl and blg_dp.
`default_nettype none

// Signed ADC sample words are summed in batches of SAMPLES_PER_READING (1 to 64);
// the batch average (truncated, negative clamps to zero) is scaled by
// scale_millivolts/1024 and mapped through a 12-point LiPo discharge curve with
// linear interpolation. Both divisions are reciprocal multiplications. The input is
// ready while a batch accumulates; the sample that closes a batch holds the input
// off through the average, scale, lookup, interpolation product, interpolation
// divide and output load steps. The level word is presented from the output register
// and waits there while the next batch accumulates; if it is still waiting when the
// next batch closes, the input stalls until it is taken. Register scale_millivolts
// lies at byte address 0, reset 4800; pready is always high.
module battery_level_gauge_core import blg_pkg::*; #(
	parameter int SAMPLES_PER_READING = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	blg_in_if.sink                 samples,
	blg_out_if.source              levels
);

	logic [SCALE_W-1:0] scale_q;
	logic               reg_hit;
	blg_cmd_t           cmd;

	assign reg_hit = (paddr[2] == REG_SCALE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	blg_ctrl #(
		.SAMPLES_PER_READING(SAMPLES_PER_READING)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(levels.valid),
		.out_ready(levels.ready),
		.cmd      (cmd)
	);

	blg_dp #(
		.SAMPLES_PER_READING(SAMPLES_PER_READING)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (samples.sample),
		.scale        (scale_q),
		.level_percent(levels.level_percent),
		.millivolts   (levels.millivolts)
	);

endmodule

`default_nettype wire
